### design/swqt_pkg.sv
// Shared types and op codes for the semaphore wait-queue table.
package swqt_pkg;
  typedef enum logic [1:0] {
    OP_BLOCK   = 2'd0,
    OP_UNBLOCK = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_PEEK    = 2'd3
  } op_e;
endpackage

### design/swqt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module swqt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### design/semaphore_wait_queue_table.sv
// Top level of the semaphore wait-queue table.
// Usage:
//  - Request channel: in_valid_i / in_stall_o with op_i, key_i, proc_id_i.
//    A request is taken when in_valid_i is high and in_stall_o is low.
//  - Result channel: out_valid_o / out_stall_i with hit_o, proc_out_o,
//    full_res_o. Exactly one result per request, in order.
//  - Ops: block appends a process to the queue of its key (allocating the
//    lowest free descriptor, or reporting full), unblock pops the oldest
//    waiter, remove unlinks a named process, peek returns the oldest waiter.
//  - Descriptor keys, valid bits, head and tail sit in flip-flops and are
//    matched combinationally like a small CAM. Per-process links (next, prev)
//    live in two synchronous RAMs with a registered read.
//  - Steps from accept to result valid: match, link read, commit. in_stall_o
//    is high from the accept until the commit, so the next request is not
//    taken before the previous one has committed.
//  - The result register frees the sequencer: the next request can be
//    taken while a finished result still waits behind out_stall_i; that
//    request then holds in its commit state until the result drains.
//  - Reset clears all valid and waiting bits at once; no clearing pass.
//    Link RAM contents are only read through a set valid/waiting bit.
module semaphore_wait_queue_table #(
  parameter int PROCS    = 16,
  parameter int KEY_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] key_i,
  input  logic [3:0]  proc_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [3:0]  proc_out_o,
  output logic        full_res_o
);
  import swqt_pkg::*;

  localparam int AW = (PROCS > 1) ? $clog2(PROCS) : 1;

  typedef enum logic [1:0] {
    S_IDLE, S_MATCH, S_LINK, S_OUT
  } state_e;

  state_e                state_q;
  op_e                   op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [AW-1:0]         pid_q;
  logic                  pid_ok_q;

  // descriptor table and per-process wait state
  logic [KEY_BITS-1:0]   sem_keys_q [PROCS];
  logic [PROCS-1:0]      sem_active_q;
  logic [AW-1:0]         sem_head_q [PROCS];
  logic [AW-1:0]         sem_tail_q [PROCS];
  logic [KEY_BITS-1:0]   wait_key_q [PROCS];
  logic [PROCS-1:0]      queued_q;

  // decision registers
  logic                  found_q;     // descriptor matched
  logic [AW-1:0]         d_q;
  logic                  free_ok_q;
  logic [AW-1:0]         free_q;
  logic [AW-1:0]         p_q;         // process being returned / unlinked
  logic [AW-1:0]         head_q, tail_q, nx_q, pr_q;

  // output register
  logic                  out_v_q, out_hit_q, out_full_q;
  logic [3:0]            out_pid_q;

  // link RAM ports
  logic          nx_we, pr_we;
  logic [AW-1:0] nx_wa, pr_wa, nx_wd, pr_wd;
  logic [AW-1:0] nx_ra, pr_ra, nx_rd, pr_rd;

  swqt_ram #(.Width(AW), .Depth(PROCS)) u_next (.clk_i, .we_i(nx_we),
    .waddr_i(nx_wa), .wdata_i(nx_wd), .raddr_i(nx_ra), .rdata_o(nx_rd));
  swqt_ram #(.Width(AW), .Depth(PROCS)) u_prev (.clk_i, .we_i(pr_we),
    .waddr_i(pr_wa), .wdata_i(pr_wd), .raddr_i(pr_ra), .rdata_o(pr_rd));

  // CAM match on the registered request; remove matches the recorded key.
  // Lowest matching and lowest free descriptor win.
  logic [KEY_BITS-1:0] match_key;
  logic                m_found, f_found;
  logic [AW-1:0]       m_idx, f_idx, m_head, p_sel;
  always_comb begin
    match_key = (op_q == OP_REMOVE) ? wait_key_q[pid_q] : key_q;
    m_found = 1'b0; m_idx = '0; f_found = 1'b0; f_idx = '0;
    for (int i = PROCS - 1; i >= 0; i--) begin
      if (sem_active_q[i] && sem_keys_q[i] == match_key) begin
        m_found = 1'b1; m_idx = AW'(i);
      end
      if (!sem_active_q[i]) begin
        f_found = 1'b1; f_idx = AW'(i);
      end
    end
    m_head = sem_head_q[m_idx];
    p_sel  = (op_q == OP_REMOVE) ? pid_q : m_head;
  end

  // links of the selected process, issued in S_MATCH, on rdata in S_LINK
  assign nx_ra = p_sel;
  assign pr_ra = p_sel;

  // request decode
  logic busy_ok, blk_new, blk_app, unl, last, commit;
  logic res_hit, res_full;
  logic [3:0] res_pid;
  assign busy_ok  = (op_q == OP_BLOCK) && pid_ok_q && (key_q != '0) && !queued_q[pid_q];
  assign blk_new  = busy_ok && !found_q && free_ok_q;
  assign blk_app  = busy_ok && found_q;
  assign unl      = found_q && (((op_q == OP_UNBLOCK) && (key_q != '0)) ||
                                ((op_q == OP_REMOVE) && pid_ok_q && queued_q[pid_q]));
  assign last     = (head_q == p_q) && (tail_q == p_q);
  assign commit   = (state_q == S_OUT) && (!out_v_q || !out_stall_i);
  assign res_full = busy_ok && !found_q && !free_ok_q;
  assign res_hit  = unl || ((op_q == OP_PEEK) && (key_q != '0) && found_q);
  assign res_pid  = res_hit ? 4'(p_q) : 4'd0;

  // link write-back: next[pid]=pid for a block in S_LINK, the rest at commit
  always_comb begin
    nx_we = 1'b0; nx_wa = pid_q; nx_wd = pid_q;
    pr_we = 1'b0; pr_wa = pid_q; pr_wd = pid_q;
    if ((state_q == S_LINK) && busy_ok) nx_we = 1'b1;
    if (commit) begin
      if (blk_new) begin
        pr_we = 1'b1;
      end else if (blk_app) begin
        // append after tail: next[tail]=pid, prev[pid]=tail
        nx_we = 1'b1; nx_wa = tail_q;
        pr_we = 1'b1; pr_wd = tail_q;
      end else if (unl && !last) begin
        if (head_q != p_q) begin
          nx_we = 1'b1; nx_wa = pr_q; nx_wd = nx_q;
        end
        if (tail_q != p_q) begin
          pr_we = 1'b1; pr_wa = nx_q; pr_wd = pr_q;
        end
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign hit_o       = out_hit_q;
  assign proc_out_o  = out_pid_q;
  assign full_res_o  = out_full_q;
  assign in_stall_o  = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_BLOCK;
      key_q        <= '0;
      pid_q        <= '0;
      pid_ok_q     <= 1'b0;
      sem_active_q <= '0;
      queued_q     <= '0;
      found_q      <= 1'b0;
      d_q          <= '0;
      free_ok_q    <= 1'b0;
      free_q       <= '0;
      p_q          <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      nx_q         <= '0;
      pr_q         <= '0;
      out_v_q      <= 1'b0;
      out_hit_q    <= 1'b0;
      out_full_q   <= 1'b0;
      out_pid_q    <= '0;
      for (int i = 0; i < PROCS; i++) begin
        sem_keys_q[i] <= '0;
        wait_key_q[i] <= '0;
        sem_head_q[i] <= '0;
        sem_tail_q[i] <= '0;
      end
    end else begin
      if (commit) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q     <= op_e'(op_i);
            key_q    <= KEY_BITS'(key_i);
            pid_q    <= AW'(proc_id_i);
            pid_ok_q <= ({28'd0, proc_id_i} < 32'(PROCS));
            state_q  <= S_MATCH;
          end
        end
        S_MATCH: begin
          found_q   <= m_found;
          d_q       <= m_idx;
          free_ok_q <= f_found;
          free_q    <= f_idx;
          head_q    <= m_head;
          tail_q    <= sem_tail_q[m_idx];
          p_q       <= p_sel;
          state_q   <= S_LINK;
        end
        S_LINK: begin
          nx_q    <= nx_rd;
          pr_q    <= pr_rd;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (commit) begin
            out_hit_q  <= res_hit;
            out_full_q <= res_full;
            out_pid_q  <= res_pid;
            if (busy_ok && !res_full) begin
              queued_q[pid_q]   <= 1'b1;
              wait_key_q[pid_q] <= key_q;
              if (blk_new) begin
                sem_active_q[free_q] <= 1'b1;
                sem_keys_q[free_q]   <= key_q;
                sem_head_q[free_q]   <= pid_q;
                sem_tail_q[free_q]   <= pid_q;
              end else begin
                sem_tail_q[d_q] <= pid_q;
              end
            end else if (unl) begin
              queued_q[p_q] <= 1'b0;
              if (last) begin
                // queue empties: free the descriptor
                sem_active_q[d_q] <= 1'b0;
                sem_keys_q[d_q]   <= '0;
              end else begin
                if (head_q == p_q) sem_head_q[d_q] <= nx_q;
                if (tail_q == p_q) sem_tail_q[d_q] <= pr_q;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && full_res_o) |-> !hit_o) else $error("full with hit");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(hit_o) &&
    $stable(proc_out_o) && $stable(full_res_o))) else $error("stalled result changed");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (state_q == S_IDLE)) else $error("accept not idle");
`endif
endmodule
